/* rtl/rcyl_pkg.sv */
`default_nettype none
package rcyl_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int CS_W         = 33;
    localparam int XY_W         = 32;
    localparam int R_W          = 31;
    localparam int LAYER_W      = 8;
    localparam int B_W          = 36;
    localparam int SQ_W         = 62;
    localparam int ROOT_W       = 31;
    localparam int NUM_W        = 37;
    localparam int PRD_W        = 70;
    localparam int DXY_W        = 40;
    localparam int QB           = 34;
    localparam int DEN_W        = 31;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_AXIAL = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    function automatic logic signed [CS_W-1:0] atan_phase(input int idx);
        logic signed [CS_W-1:0] v;
        case (idx)
            0:  v = 33'sh20000000;
            1:  v = 33'sh12E4051E;
            2:  v = 33'sh09FB385B;
            3:  v = 33'sh051111D4;
            4:  v = 33'sh028B0D43;
            5:  v = 33'sh0145D7E1;
            6:  v = 33'sh00A2F61E;
            7:  v = 33'sh00517C55;
            8:  v = 33'sh0028BE53;
            9:  v = 33'sh00145F2F;
            10: v = 33'sh000A2F98;
            11: v = 33'sh000517CC;
            12: v = 33'sh00028BE6;
            13: v = 33'sh000145F3;
            14: v = 33'sh0000A2FA;
            15: v = 33'sh0000517D;
            16: v = 33'sh000028BE;
            17: v = 33'sh0000145F;
            18: v = 33'sh00000A30;
            19: v = 33'sh00000518;
            20: v = 33'sh0000028C;
            21: v = 33'sh00000146;
            22: v = 33'sh000000A3;
            23: v = 33'sh00000051;
            24: v = 33'sh00000029;
            25: v = 33'sh00000014;
            26: v = 33'sh0000000A;
            27: v = 33'sh00000005;
            28: v = 33'sh00000003;
            29: v = 33'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [XY_W-1:0] x0;
        logic signed [XY_W-1:0] y0;
        logic signed [XY_W-1:0] z0;
        logic [R_W-1:0]         r;
        logic [LAYER_W-1:0]     layer;
        logic                   axial;
        logic [1:0]             qt;
        logic [1:0]             qp;
    } t_cd_side;

    typedef struct packed {
        logic signed [XY_W-1:0] x0;
        logic signed [XY_W-1:0] y0;
        logic signed [XY_W-1:0] z0;
        logic [R_W-1:0]         r;
        logic [LAYER_W-1:0]     layer;
        logic                   axial;
        logic                   miss;
        logic signed [CS_W-1:0] st;
        logic signed [CS_W-1:0] ct;
        logic signed [CS_W-1:0] sp;
        logic signed [CS_W-1:0] cp;
        logic signed [B_W-1:0]  b;
    } t_trk;

    typedef struct packed {
        logic signed [XY_W-1:0]  x0;
        logic signed [XY_W-1:0]  y0;
        logic signed [XY_W-1:0]  z0;
        logic [LAYER_W-1:0]      layer;
        logic                    axial;
        logic                    miss;
        logic                    szero;
        logic                    nneg;
        logic                    over;
        logic signed [DXY_W-1:0] dx;
        logic signed [DXY_W-1:0] dy;
    } t_div_side;

endpackage
`default_nettype wire

/* rtl/ray_cylinder_hit_from_angles.sv */
// throughput: one item per cycle, busy never rises
// latency set by the 30-cell cordic chains, the 31-cell root chain and the
// 34-cell quotient chain plus ten arithmetic stages between and after them
// reset (synchronous, active low) clears the valid line only; results are
// shown for one cycle each since the receiver cannot stall
`default_nettype none
module ray_cylinder_hit_from_angles #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_origin_x,
    input  wire logic signed [31:0] i_origin_y,
    input  wire logic signed [31:0] i_origin_z,
    input  wire logic [15:0]        i_polar_angle,
    input  wire logic [15:0]        i_azimuth_angle,
    input  wire logic [30:0]        i_radius,
    input  wire logic [7:0]         i_layer,
    output logic                    o_valid,
    output logic signed [31:0]      o_hit_x,
    output logic signed [31:0]      o_hit_y,
    output logic signed [31:0]      o_hit_z,
    output logic [7:0]              o_layer_out,
    output logic [1:0]              o_status
);
    import rcyl_pkg::*;

    localparam int LAT = CORDIC_STEPS + 6 + ROOT_W + 3 + QB + 1;

    logic [LAT-1:0] r_vld;

    // angle phases
    logic [31:0] w_ph_t, w_ph_p;
    assign w_ph_t = {16'b0, i_polar_angle} << (32 - ANGLE_BITS);
    assign w_ph_p = {16'b0, i_azimuth_angle} << (32 - ANGLE_BITS);

    // cordic chains
    logic signed [CS_W-1:0] w_tx [CORDIC_STEPS];
    logic signed [CS_W-1:0] w_ty [CORDIC_STEPS];
    logic signed [CS_W-1:0] w_tz [CORDIC_STEPS];
    logic signed [CS_W-1:0] w_px [CORDIC_STEPS];
    logic signed [CS_W-1:0] w_py [CORDIC_STEPS];
    logic signed [CS_W-1:0] w_pz [CORDIC_STEPS];
    t_cd_side               r_cd [CORDIC_STEPS];

    genvar k;
    generate
        for (k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
            if (k == 0) begin : g_first
                rcyl_cordic_cell #(.STEP(k)) u_t (
                    .i_clk(i_clk), .i_x(CORDIC_GAIN), .i_y('0),
                    .i_z({3'b0, w_ph_t[29:0]}),
                    .o_x(w_tx[k]), .o_y(w_ty[k]), .o_z(w_tz[k])
                );
                rcyl_cordic_cell #(.STEP(k)) u_p (
                    .i_clk(i_clk), .i_x(CORDIC_GAIN), .i_y('0),
                    .i_z({3'b0, w_ph_p[29:0]}),
                    .o_x(w_px[k]), .o_y(w_py[k]), .o_z(w_pz[k])
                );
            end else begin : g_next
                rcyl_cordic_cell #(.STEP(k)) u_t (
                    .i_clk(i_clk), .i_x(w_tx[k-1]), .i_y(w_ty[k-1]), .i_z(w_tz[k-1]),
                    .o_x(w_tx[k]), .o_y(w_ty[k]), .o_z(w_tz[k])
                );
                rcyl_cordic_cell #(.STEP(k)) u_p (
                    .i_clk(i_clk), .i_x(w_px[k-1]), .i_y(w_py[k-1]), .i_z(w_pz[k-1]),
                    .o_x(w_px[k]), .o_y(w_py[k]), .o_z(w_pz[k])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_cd[0].x0    <= i_origin_x;
        r_cd[0].y0    <= i_origin_y;
        r_cd[0].z0    <= i_origin_z;
        r_cd[0].r     <= i_radius;
        r_cd[0].layer <= i_layer;
        r_cd[0].axial <= (w_ph_t == 32'h0) || (w_ph_t == 32'h8000_0000);
        r_cd[0].qt    <= w_ph_t[31:30];
        r_cd[0].qp    <= w_ph_p[31:30];
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            r_cd[i] <= r_cd[i-1];
        end
    end

    // quadrant unfold
    localparam int CL = CORDIC_STEPS - 1;
    t_trk n_t2, r_t2;

    always_comb begin
        n_t2       = '0;
        n_t2.x0    = r_cd[CL].x0;
        n_t2.y0    = r_cd[CL].y0;
        n_t2.z0    = r_cd[CL].z0;
        n_t2.r     = r_cd[CL].r;
        n_t2.layer = r_cd[CL].layer;
        n_t2.axial = r_cd[CL].axial;
        case (r_cd[CL].qt)
            2'd0:    begin n_t2.ct = w_tx[CL];  n_t2.st = w_ty[CL];  end
            2'd1:    begin n_t2.ct = -w_ty[CL]; n_t2.st = w_tx[CL];  end
            2'd2:    begin n_t2.ct = -w_tx[CL]; n_t2.st = -w_ty[CL]; end
            default: begin n_t2.ct = w_ty[CL];  n_t2.st = -w_tx[CL]; end
        endcase
        case (r_cd[CL].qp)
            2'd0:    begin n_t2.cp = w_px[CL];  n_t2.sp = w_py[CL];  end
            2'd1:    begin n_t2.cp = -w_py[CL]; n_t2.sp = w_px[CL];  end
            2'd2:    begin n_t2.cp = -w_px[CL]; n_t2.sp = -w_py[CL]; end
            default: begin n_t2.cp = w_py[CL];  n_t2.sp = -w_px[CL]; end
        endcase
    end

    // b and c
    t_trk                    r_t3, r_t4, r_t5, r_t6, r_t7;
    t_trk                    n_t4, n_t5;
    logic signed [64:0]      r_p_xc, r_p_ys, r_p_yc, r_p_xs;
    logic signed [65:0]      w_sb, w_sc;
    logic signed [B_W-1:0]   r_c4;
    logic [B_W-1:0]          w_cabs;
    logic [R_W-1:0]          r_cabs5;
    logic [SQ_W-1:0]         r_rr6, r_cc6, r_v7;

    assign w_sb   = r_p_xc + r_p_ys + 66'sd536870912;
    assign w_sc   = r_p_yc - r_p_xs + 66'sd536870912;
    assign w_cabs = r_c4[B_W-1] ? -r_c4 : r_c4;

    always_comb begin
        n_t4      = r_t3;
        n_t4.b    = w_sb[65:30];
        n_t5      = r_t4;
        n_t5.miss = w_cabs > {(B_W-R_W)'(0), r_t4.r};
    end

    always_ff @(posedge i_clk) begin
        r_t2   <= n_t2;
        r_t3   <= r_t2;
        r_p_xc <= r_t2.x0 * r_t2.cp;
        r_p_ys <= r_t2.y0 * r_t2.sp;
        r_p_yc <= r_t2.y0 * r_t2.cp;
        r_p_xs <= r_t2.x0 * r_t2.sp;
        r_t4   <= n_t4;
        r_c4   <= w_sc[65:30];
        r_t5      <= n_t5;
        r_cabs5   <= w_cabs[R_W-1:0];
        r_t6  <= r_t5;
        r_rr6 <= r_t5.r * r_t5.r;
        r_cc6 <= r_cabs5 * r_cabs5;
        r_t7  <= r_t6;
        r_v7  <= r_rr6 - r_cc6;
    end

    // square root chain
    logic [SQ_W-1:0]   w_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0] w_sq_root [ROOT_W];
    t_trk              r_tq      [ROOT_W];

    generate
        for (k = 0; k < ROOT_W; k++) begin : g_sqrt
            if (k == 0) begin : g_first
                rcyl_sqrt_cell #(.BIT(ROOT_W - 1 - k)) u_c (
                    .i_clk(i_clk), .i_rem(r_v7), .i_root('0),
                    .o_rem(w_sq_rem[k]), .o_root(w_sq_root[k])
                );
            end else begin : g_next
                rcyl_sqrt_cell #(.BIT(ROOT_W - 1 - k)) u_c (
                    .i_clk(i_clk), .i_rem(w_sq_rem[k-1]), .i_root(w_sq_root[k-1]),
                    .o_rem(w_sq_rem[k]), .o_root(w_sq_root[k])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_tq[0] <= r_t7;
        for (int i = 1; i < ROOT_W; i++) begin
            r_tq[i] <= r_tq[i-1];
        end
    end

    // offsets along the ray
    localparam int SL = ROOT_W - 1;
    t_trk                     r_t8, r_t9;
    logic signed [NUM_W-1:0]  r_num8;
    logic signed [PRD_W-1:0]  r_pcx, r_pcy, r_pn;
    logic [CS_W-1:0]          w_sabs;
    logic [DEN_W-1:0]         r_sabs9, r_sabs10;
    logic                     r_szero9;
    logic signed [PRD_W-1:0]  w_rx, w_ry;
    t_div_side                r_dv10;
    logic [PRD_W-1:0]         r_nabs10;

    assign w_sabs = r_t8.st[CS_W-1] ? -r_t8.st : r_t8.st;
    assign w_rx   = r_pcx + 70'sd536870912;
    assign w_ry   = r_pcy + 70'sd536870912;

    always_ff @(posedge i_clk) begin
        r_t8     <= r_tq[SL];
        r_num8   <= $signed({(NUM_W-ROOT_W)'(0), w_sq_root[SL]}) - r_tq[SL].b;
        r_t9     <= r_t8;
        r_pcx    <= r_num8 * r_t8.cp;
        r_pcy    <= r_num8 * r_t8.sp;
        r_pn     <= r_num8 * r_t8.ct;
        r_sabs9  <= w_sabs[DEN_W-1:0];
        r_szero9 <= r_t8.st == '0;
        r_dv10.x0    <= r_t9.x0;
        r_dv10.y0    <= r_t9.y0;
        r_dv10.z0    <= r_t9.z0;
        r_dv10.layer <= r_t9.layer;
        r_dv10.axial <= r_t9.axial;
        r_dv10.miss  <= r_t9.miss;
        r_dv10.szero <= r_szero9;
        r_dv10.nneg  <= r_pn[PRD_W-1];
        r_dv10.over  <= 1'b0;
        r_dv10.dx    <= r_t9.st[CS_W-1] ? -w_rx[PRD_W-1:30] : w_rx[PRD_W-1:30];
        r_dv10.dy    <= r_t9.st[CS_W-1] ? -w_ry[PRD_W-1:30] : w_ry[PRD_W-1:30];
        r_nabs10     <= r_pn[PRD_W-1] ? -r_pn : r_pn;
        r_sabs10     <= r_sabs9;
    end

    // quotient chain
    logic [PRD_W-1:0] w_dv_rem [QB];
    logic [QB-1:0]    w_dv_q   [QB];
    logic [DEN_W-1:0] w_dv_d   [QB];
    t_div_side        r_dv     [QB];
    t_div_side        n_dv0;

    generate
        for (k = 0; k < QB; k++) begin : g_div
            if (k == 0) begin : g_first
                rcyl_div_cell #(.BIT(QB - 1 - k)) u_c (
                    .i_clk(i_clk), .i_rem(r_nabs10), .i_q('0), .i_d(r_sabs10),
                    .o_rem(w_dv_rem[k]), .o_q(w_dv_q[k]), .o_d(w_dv_d[k])
                );
            end else begin : g_next
                rcyl_div_cell #(.BIT(QB - 1 - k)) u_c (
                    .i_clk(i_clk), .i_rem(w_dv_rem[k-1]), .i_q(w_dv_q[k-1]),
                    .i_d(w_dv_d[k-1]),
                    .o_rem(w_dv_rem[k]), .o_q(w_dv_q[k]), .o_d(w_dv_d[k])
                );
            end
        end
    endgenerate

    always_comb begin
        n_dv0      = r_dv10;
        n_dv0.over = r_nabs10[PRD_W-1:QB] >= {(PRD_W-QB-DEN_W)'(0), r_sabs10};
    end

    always_ff @(posedge i_clk) begin
        r_dv[0] <= n_dv0;
        for (int i = 1; i < QB; i++) begin
            r_dv[i] <= r_dv[i-1];
        end
    end

    // final sums and clamping
    localparam int DL = QB - 1;
    logic [QB:0]            w_qm;
    logic signed [QB+1:0]   w_qs;
    logic signed [DXY_W:0]  w_hx, w_hy;
    logic signed [QB+2:0]   w_hz;
    logic                   w_sx, w_sy, w_sz;
    logic signed [31:0]     w_cx, w_cy, w_cz;
    logic signed [31:0]     n_hit_x, n_hit_y, n_hit_z;
    logic [7:0]             n_layer;
    logic [1:0]             n_status;
    logic signed [31:0]     r_hit_x, r_hit_y, r_hit_z;
    logic [7:0]             r_layer;
    logic [1:0]             r_status;

    assign w_qm = r_dv[DL].over ? ((QB+1)'(1) << QB) : {1'b0, w_dv_q[DL]};
    assign w_qs = r_dv[DL].nneg ? -$signed({1'b0, w_qm}) : $signed({1'b0, w_qm});
    assign w_hx = r_dv[DL].x0 + r_dv[DL].dx;
    assign w_hy = r_dv[DL].y0 + r_dv[DL].dy;
    assign w_hz = r_dv[DL].z0 + w_qs;

    always_comb begin
        w_sx = 1'b1;
        w_sy = 1'b1;
        w_sz = 1'b1;
        if (w_hx > 41'sd2147483647)       w_cx = 32'sh7FFF_FFFF;
        else if (w_hx < -41'sd2147483648) w_cx = 32'sh8000_0000;
        else begin w_cx = w_hx[31:0]; w_sx = 1'b0; end
        if (w_hy > 41'sd2147483647)       w_cy = 32'sh7FFF_FFFF;
        else if (w_hy < -41'sd2147483648) w_cy = 32'sh8000_0000;
        else begin w_cy = w_hy[31:0]; w_sy = 1'b0; end
        if (w_hz > 37'sd2147483647)       w_cz = 32'sh7FFF_FFFF;
        else if (w_hz < -37'sd2147483648) w_cz = 32'sh8000_0000;
        else begin w_cz = w_hz[31:0]; w_sz = 1'b0; end
    end

    always_comb begin
        if (r_dv[DL].axial) begin
            n_hit_x  = '0;
            n_hit_y  = '0;
            n_hit_z  = '0;
            n_layer  = '0;
            n_status = ST_AXIAL;
        end else if (r_dv[DL].miss) begin
            n_hit_x  = '0;
            n_hit_y  = '0;
            n_hit_z  = '0;
            n_layer  = r_dv[DL].layer;
            n_status = ST_MISS;
        end else if (r_dv[DL].szero) begin
            n_hit_x  = r_dv[DL].x0;
            n_hit_y  = r_dv[DL].y0;
            n_hit_z  = r_dv[DL].z0;
            n_layer  = r_dv[DL].layer;
            n_status = ST_SAT;
        end else begin
            n_hit_x  = w_cx;
            n_hit_y  = w_cy;
            n_hit_z  = w_cz;
            n_layer  = r_dv[DL].layer;
            n_status = (w_sx || w_sy || w_sz) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_x  <= n_hit_x;
        r_hit_y  <= n_hit_y;
        r_hit_z  <= n_hit_z;
        r_layer  <= n_layer;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    assign busy        = 1'b0;
    assign o_valid     = r_vld[LAT-1];
    assign o_hit_x     = r_hit_x;
    assign o_hit_y     = r_hit_y;
    assign o_hit_z     = r_hit_z;
    assign o_layer_out = r_layer;
    assign o_status    = r_status;
endmodule
`default_nettype wire

/* rtl/rcyl_cordic_cell.sv */
`default_nettype none
module rcyl_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic                            i_clk,
    input  wire logic signed [rcyl_pkg::CS_W-1:0] i_x,
    input  wire logic signed [rcyl_pkg::CS_W-1:0] i_y,
    input  wire logic signed [rcyl_pkg::CS_W-1:0] i_z,
    output logic signed [rcyl_pkg::CS_W-1:0]      o_x,
    output logic signed [rcyl_pkg::CS_W-1:0]      o_y,
    output logic signed [rcyl_pkg::CS_W-1:0]      o_z
);
    import rcyl_pkg::*;

    localparam logic signed [CS_W-1:0] ANG = atan_phase(STEP);

    logic signed [CS_W-1:0] r_x, r_y, r_z;
    logic signed [CS_W-1:0] n_x, n_y, n_z;
    logic signed [CS_W-1:0] w_dx, w_dy;

    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    always_comb begin
        if (!i_z[CS_W-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ANG;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule
`default_nettype wire

/* rtl/rcyl_sqrt_cell.sv */
`default_nettype none
module rcyl_sqrt_cell #(
    parameter int BIT = 0
) (
    input  wire logic                          i_clk,
    input  wire logic [rcyl_pkg::SQ_W-1:0]     i_rem,
    input  wire logic [rcyl_pkg::ROOT_W-1:0]   i_root,
    output logic [rcyl_pkg::SQ_W-1:0]          o_rem,
    output logic [rcyl_pkg::ROOT_W-1:0]        o_root
);
    import rcyl_pkg::*;

    localparam int CW = SQ_W + 1;

    logic [SQ_W-1:0]   r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [CW-1:0]     w_cand;

    // (root + 2^bit)^2 - root^2
    assign w_cand = ({(CW-ROOT_W)'(0), i_root} << (BIT + 1)) + (CW'(1) << (2 * BIT));

    always_comb begin
        if ({1'b0, i_rem} >= w_cand) begin
            n_rem  = i_rem - w_cand[SQ_W-1:0];
            n_root = i_root | (ROOT_W'(1) << BIT);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule
`default_nettype wire

/* rtl/rcyl_div_cell.sv */
`default_nettype none
module rcyl_div_cell #(
    parameter int BIT = 0
) (
    input  wire logic                         i_clk,
    input  wire logic [rcyl_pkg::PRD_W-1:0]   i_rem,
    input  wire logic [rcyl_pkg::QB-1:0]      i_q,
    input  wire logic [rcyl_pkg::DEN_W-1:0]   i_d,
    output logic [rcyl_pkg::PRD_W-1:0]        o_rem,
    output logic [rcyl_pkg::QB-1:0]           o_q,
    output logic [rcyl_pkg::DEN_W-1:0]        o_d
);
    import rcyl_pkg::*;

    logic [PRD_W-1:0] r_rem, n_rem;
    logic [QB-1:0]    r_q, n_q;
    logic [DEN_W-1:0] r_d;
    logic [PRD_W-1:0] w_sub;

    assign w_sub = {(PRD_W-DEN_W)'(0), i_d} << BIT;

    always_comb begin
        if (i_rem >= w_sub) begin
            n_rem = i_rem - w_sub;
            n_q   = i_q | (QB'(1) << BIT);
        end else begin
            n_rem = i_rem;
            n_q   = i_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= i_d;
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;
    assign o_d   = r_d;
endmodule
`default_nettype wire
